// ----- sv/utf16be_confidence_scorer_defines.svh -----
// Assertion macros shared by the scorer RTL.
// With SYNTH defined, the macros expand to nothing.
`ifndef UTF16BE_CONFIDENCE_SCORER_DEFINES_SVH
`define UTF16BE_CONFIDENCE_SCORER_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define UCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define UCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define UCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/ucs_pkg.sv -----
package ucs_pkg;

	localparam int BYTE_W         = 8;
	localparam int SCORE_W        = 7;
	localparam int WINDOW_DEFAULT = 2048;

	localparam logic [BYTE_W-1:0] BOM_FIRST  = 8'hFE;
	localparam logic [BYTE_W-1:0] BOM_SECOND = 8'hFF;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

	localparam logic [SCORE_W-1:0] SCORE_BOM    = 7'd100;
	localparam logic [SCORE_W-1:0] SCORE_PLAIN  = 7'd70;
	localparam logic [SCORE_W-1:0] CRLF_PENALTY = 7'd25;

	localparam int CRLF_W = 3;
	localparam logic [CRLF_W-1:0] CRLF_MAX = 3'd4;

endpackage

// ----- sv/utf16be_confidence_scorer.sv -----
// Scores a byte stream for how likely it is big-endian UTF-16 text.
//
// Input channel (s_axis): one sample byte per transfer, tlast on the final
// byte of a sample. Output channel (m_axis): one transfer per sample, carrying
// the confidence percent (0 to 100), sent after the sample's final byte.
//
// Throughput is one byte per cycle, but a final byte waits while the result
// register is not free. Each byte passes an input register and is then folded
// into the per-sample counters and flags; the score is formed from those
// counters in the same cycle and held in the result register. m_axis_tvalid
// therefore rises as the final byte leaves the input register.
//
// Reset clears all counters and flags, and both the input and result
// registers become empty. The counters also clear after every final byte, so
// samples may follow each other with no gap. While the receiver stalls, the
// result is held and non-final bytes keep flowing; a second final byte waits
// in the input register until the result register is free.
`include "utf16be_confidence_scorer_defines.svh"

module utf16be_confidence_scorer
	import ucs_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] sample_byte
	input  logic              s_axis_tlast,   // last_byte
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata    // [6:0] confidence, [7] zero
);

	localparam int PW   = $clog2(WINDOW + 1);
	localparam int CW   = $clog2(WINDOW / 2 + 1);
	localparam int CMPW = PW + 3;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Per-sample state
	logic              prev_cr_q;
	logic              first_fe_q;
	logic              bom_q;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     zero_cnt_q;
	logic [CRLF_W-1:0] crlf_q;

	// Result register
	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;

	logic               out_free;
	logic               adv;
	logic               bom_next;
	logic [CRLF_W-1:0]  crlf_next;
	logic               count_zero;
	logic [PW-1:0]      length;
	logic [CMPW-1:0]    zero_x5;
	logic [CMPW-1:0]    length_x2;
	logic [SCORE_W-1:0] base_score;
	logic [SCORE_W-1:0] score;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv           = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || adv;

	always_comb begin
		bom_next = bom_q;
		if (pos_q == PW'(1) && first_fe_q && byte_s1 == BOM_SECOND) begin
			bom_next = 1'b1;
		end
		crlf_next = crlf_q;
		if (prev_cr_q && byte_s1 == CHAR_LF && crlf_q < CRLF_MAX) begin
			crlf_next = crlf_q + CRLF_W'(1);
		end
		// A zero at an even position counts only when its pair partner is in the window.
		count_zero = !last_s1 && !pos_q[0] && ((PW + 1)'(pos_q) + (PW + 1)'(1) < (PW + 1)'(WINDOW))
			&& byte_s1 == '0;
	end

	always_comb begin
		length    = (pos_q < PW'(WINDOW)) ? pos_q + PW'(1) : PW'(WINDOW);
		zero_x5   = (CMPW'(zero_cnt_q) << 2) + CMPW'(zero_cnt_q);
		length_x2 = CMPW'(length) << 1;
		if (bom_next) begin
			base_score = SCORE_BOM - SCORE_W'(crlf_next) * CRLF_PENALTY;
		end else if (crlf_next <= CRLF_W'(2)) begin
			base_score = SCORE_PLAIN - SCORE_W'(crlf_next) * CRLF_PENALTY;
		end else begin
			base_score = '0;
		end
		if (pos_q == '0) begin
			score = SCORE_PLAIN;
		end else if (base_score < SCORE_BOM && zero_x5 >= length_x2) begin
			score = SCORE_BOM;
		end else begin
			score = base_score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cr_q  <= 1'b0;
			first_fe_q <= 1'b0;
			bom_q      <= 1'b0;
			pos_q      <= '0;
			zero_cnt_q <= '0;
			crlf_q     <= '0;
		end else if (adv) begin
			if (last_s1) begin
				prev_cr_q  <= 1'b0;
				first_fe_q <= 1'b0;
				bom_q      <= 1'b0;
				pos_q      <= '0;
				zero_cnt_q <= '0;
				crlf_q     <= '0;
			end else begin
				prev_cr_q <= (byte_s1 == CHAR_CR);
				if (pos_q == '0) begin
					first_fe_q <= (byte_s1 == BOM_FIRST);
				end
				bom_q  <= bom_next;
				crlf_q <= crlf_next;
				if (pos_q < PW'(WINDOW)) begin
					pos_q <= pos_q + PW'(1);
				end
				if (count_zero) begin
					zero_cnt_q <= zero_cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_score_q <= score;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = BYTE_W'(out_score_q);

	`UCS_ASSERT(a_score_range, clk, arst_n, !out_valid_q || out_score_q <= SCORE_BOM, "confidence above 100")
	`UCS_ASSERT(a_crlf_sat, clk, arst_n, crlf_q <= CRLF_MAX, "CR LF counter past saturation")
	`UCS_ASSERT(a_pos_sat, clk, arst_n, pos_q <= PW'(WINDOW), "byte position past window")
	`UCS_ASSERT(a_zero_bound, clk, arst_n, (PW + 1)'(zero_cnt_q) * (PW + 1)'(2) <= (PW + 1)'(pos_q) + (PW + 1)'(1), "zero count exceeds even positions")
	`UCS_ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv && last_s1, pos_q == '0 && crlf_q == '0 && zero_cnt_q == '0 && out_valid_q, "state not cleared after final byte")

endmodule
